// ===== rtl/hbd_pkg.sv =====
// ----------------------------------------------------------------------------
// hbd_pkg
// types, codes and constants shared by the hyperram bus decoder files
// ----------------------------------------------------------------------------
package hbd_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int LAT_W      = 4;
  localparam int LEFT_W     = 6;
  localparam int CA_W       = 48;
  localparam int CA_BYTES   = 6;

  localparam logic [CFG_ADDR_W-1:0] REG_LATENCY_ADDR = 3'd0;
  localparam logic [LAT_W-1:0]      LATENCY_RESET    = 4'd3;
  localparam logic [LAT_W-1:0]      LATENCY_MIN      = 4'd2;

  typedef enum logic [1:0] {
    OP_CS    = 2'd0,
    OP_CLK   = 2'd1,
    OP_RWDS  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_SELECT   = 3'd0,
    KIND_DESELECT = 3'd1,
    KIND_CA       = 3'd2,
    KIND_WAIT     = 3'd3,
    KIND_DATA     = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_DESEL = 3'd1,
    PH_CA    = 3'd2,
    PH_RWAIT = 3'd3,
    PH_WWAIT = 3'd4,
    PH_READ  = 3'd5,
    PH_WRITE = 3'd6
  } phase_t;

  typedef struct packed {
    logic [1:0] op;
    logic       cs_n_level;
    logic       rwds_level;
    logic [7:0] dq_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  symbol_kind;
    logic [47:0] symbol_value;
    logic [31:0] decoded_address;
    logic        is_read;
    logic        is_register;
    logic        is_linear;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

endpackage

// ===== rtl/hbd_cfg.sv =====
// ----------------------------------------------------------------------------
// hbd_cfg
// apb register file holding the initial latency setting
// ----------------------------------------------------------------------------
module hbd_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [hbd_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [hbd_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [hbd_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready,
  output logic [hbd_pkg::LAT_W-1:0]        latency
);

  logic [hbd_pkg::LAT_W-1:0] latency_r;
  logic [hbd_pkg::LAT_W-1:0] latency_nxt;
  logic                      hit;

  assign cfg_pready = 1'b1;
  assign hit        = (cfg_paddr[hbd_pkg::CFG_ADDR_W-1] ==
                       hbd_pkg::REG_LATENCY_ADDR[hbd_pkg::CFG_ADDR_W-1]);

  always_comb begin
    latency_nxt = latency_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && hit) begin
      latency_nxt = cfg_pwdata[hbd_pkg::LAT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latency_r <= hbd_pkg::LATENCY_RESET;
    end else begin
      latency_r <= latency_nxt;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (hit) begin
      cfg_prdata = {{(hbd_pkg::CFG_DATA_W-hbd_pkg::LAT_W){1'b0}}, latency_r};
    end
  end

  assign latency = latency_r;

endmodule

// ===== rtl/hbd_core.sv =====
// ----------------------------------------------------------------------------
// hbd_core
// transaction state machine: command-address capture, latency count, data
// ----------------------------------------------------------------------------
module hbd_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  hbd_pkg::in_item_t          item,
  input  logic [hbd_pkg::LAT_W-1:0]  latency,
  output hbd_pkg::result_t           result
);

  hbd_pkg::phase_t             phase_r, phase_nxt;
  logic [hbd_pkg::CA_W-1:0]    ca_shift_r, ca_shift_nxt;
  logic [2:0]                  ca_count_r, ca_count_nxt;
  logic                        fcp_r, fcp_nxt;
  logic [hbd_pkg::LEFT_W-1:0]  left_r, left_nxt;

  logic [hbd_pkg::CA_W-1:0]    shift_new;
  logic [2:0]                  count_new;
  logic [hbd_pkg::LEFT_W-1:0]  left_dec;
  logic [hbd_pkg::LEFT_W-1:0]  left_init;
  logic [hbd_pkg::LAT_W-1:0]   lat_eff;
  logic [hbd_pkg::LEFT_W-1:0]  lat_cycles;
  logic                        cs_high;
  logic                        is_clk;
  logic                        ca_done;

  assign cs_high   = item.cs_n_level;
  assign is_clk    = (item.op == hbd_pkg::OP_CLK);
  assign shift_new = {ca_shift_r[hbd_pkg::CA_W-9:0], item.dq_byte};
  assign count_new = ca_count_r + 3'd1;
  assign ca_done   = (count_new >= 3'(hbd_pkg::CA_BYTES));
  assign left_dec  = left_r - 6'd1;
  assign lat_eff   = (latency < hbd_pkg::LATENCY_MIN) ? hbd_pkg::LATENCY_MIN : latency;
  assign lat_cycles = item.rwds_level ? {lat_eff, 2'b00} : {1'b0, lat_eff, 1'b0};
  assign left_init = lat_cycles - 6'd2;

  // next state
  always_comb begin
    phase_nxt    = phase_r;
    ca_shift_nxt = ca_shift_r;
    ca_count_nxt = ca_count_r;
    fcp_nxt      = fcp_r;
    left_nxt     = left_r;
    if (accept) begin
      case (phase_r)
        hbd_pkg::PH_DESEL: begin
          if (!cs_high) begin
            phase_nxt    = hbd_pkg::PH_CA;
            ca_shift_nxt = '0;
            ca_count_nxt = '0;
            fcp_nxt      = 1'b1;
          end
        end
        hbd_pkg::PH_CA: begin
          if (cs_high) begin
            phase_nxt = hbd_pkg::PH_DESEL;
          end else if (is_clk) begin
            ca_shift_nxt = shift_new;
            ca_count_nxt = count_new;
            if (fcp_r) begin
              fcp_nxt = 1'b0;
            end else if (ca_done) begin
              left_nxt = left_init;
              if (shift_new[47]) begin
                phase_nxt = hbd_pkg::PH_RWAIT;
              end else if (shift_new[46]) begin
                phase_nxt = hbd_pkg::PH_WRITE;
              end else begin
                phase_nxt = hbd_pkg::PH_WWAIT;
              end
            end
          end
        end
        hbd_pkg::PH_RWAIT, hbd_pkg::PH_WWAIT: begin
          if (cs_high) begin
            phase_nxt = hbd_pkg::PH_DESEL;
          end else if (is_clk) begin
            left_nxt = left_dec;
            if (left_dec == '0) begin
              phase_nxt = (phase_r == hbd_pkg::PH_RWAIT) ? hbd_pkg::PH_READ :
                                                           hbd_pkg::PH_WRITE;
            end
          end
        end
        hbd_pkg::PH_READ, hbd_pkg::PH_WRITE: begin
          if (cs_high) begin
            phase_nxt = hbd_pkg::PH_DESEL;
          end
        end
        default: begin
          phase_nxt = cs_high ? hbd_pkg::PH_DESEL : hbd_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // result
  always_comb begin
    result = '0;
    case (phase_r)
      hbd_pkg::PH_CA: begin
        if (cs_high) begin
          result.valid            = 1'b1;
          result.item.symbol_kind = hbd_pkg::KIND_DESELECT;
        end else if (is_clk) begin
          if (fcp_r) begin
            result.valid            = 1'b1;
            result.item.symbol_kind = hbd_pkg::KIND_SELECT;
          end else if (ca_done) begin
            result.valid                = 1'b1;
            result.item.symbol_kind     = hbd_pkg::KIND_CA;
            result.item.symbol_value    = shift_new;
            result.item.decoded_address = {shift_new[44:16], shift_new[2:0]};
            result.item.is_read         = shift_new[47];
            result.item.is_register     = shift_new[46];
            result.item.is_linear       = shift_new[45];
          end
        end
      end
      hbd_pkg::PH_RWAIT, hbd_pkg::PH_WWAIT: begin
        if (cs_high) begin
          result.valid            = 1'b1;
          result.item.symbol_kind = hbd_pkg::KIND_DESELECT;
        end else if (is_clk && left_dec == '0) begin
          result.valid            = 1'b1;
          result.item.symbol_kind = hbd_pkg::KIND_WAIT;
        end
      end
      hbd_pkg::PH_READ, hbd_pkg::PH_WRITE: begin
        if (cs_high) begin
          result.valid            = 1'b1;
          result.item.symbol_kind = hbd_pkg::KIND_DESELECT;
        end else if ((phase_r == hbd_pkg::PH_READ && item.op == hbd_pkg::OP_RWDS) ||
                     (phase_r == hbd_pkg::PH_WRITE && is_clk)) begin
          result.valid             = 1'b1;
          result.item.symbol_kind  = hbd_pkg::KIND_DATA;
          result.item.symbol_value = {40'd0, item.dq_byte};
        end
      end
      default: begin
        result = '0;
      end
    endcase
    result.valid = result.valid && accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= hbd_pkg::PH_IDLE;
      ca_shift_r <= '0;
      ca_count_r <= '0;
      fcp_r      <= 1'b0;
      left_r     <= '0;
    end else begin
      phase_r    <= phase_nxt;
      ca_shift_r <= ca_shift_nxt;
      ca_count_r <= ca_count_nxt;
      fcp_r      <= fcp_nxt;
      left_r     <= left_nxt;
    end
  end

  wait_exit_a: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !cs_high && is_clk && phase_r == hbd_pkg::PH_RWAIT && left_dec == '0)
    |=> phase_r == hbd_pkg::PH_READ)
    else $error("read wait did not enter data phase");

  wait_left_a: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == hbd_pkg::PH_RWAIT || phase_r == hbd_pkg::PH_WWAIT) |->
    (left_r != '0 && left_r <= 6'd58))
    else $error("latency count out of range");

  ca_count_a: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == hbd_pkg::PH_CA) |-> (ca_count_r < 3'(hbd_pkg::CA_BYTES)))
    else $error("command-address byte count overran");

endmodule

// ===== rtl/hbd_out_buf.sv =====
// ----------------------------------------------------------------------------
// hbd_out_buf
// result register with one skid entry toward the output channel
// ----------------------------------------------------------------------------
module hbd_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  hbd_pkg::result_t   result,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output hbd_pkg::out_item_t out_item
);

  logic               main_v_r, main_v_nxt;
  logic               skid_v_r, skid_v_nxt;
  hbd_pkg::out_item_t main_r, main_nxt;
  hbd_pkg::out_item_t skid_r, skid_nxt;
  logic               pop;

  assign pop       = main_v_r && !out_stall;
  assign full      = skid_v_r;
  assign out_valid = main_v_r;
  assign out_item  = main_r;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (!main_v_r || pop) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end else begin
        main_v_nxt = result.valid;
        main_nxt   = result.item;
      end
    end else if (result.valid) begin
      skid_v_nxt = 1'b1;
      skid_nxt   = result.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  skid_main_a: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid entry held without a result in front");

  no_overrun_a: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> !result.valid)
    else $error("result arrived while buffer full");

  to_skid_a: assert property (@(posedge clk) disable iff (!rst_n)
    (result.valid && main_v_r && !pop) |=> skid_v_r)
    else $error("result lost while output stalled");

endmodule

// ===== rtl/hyperram_bus_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// hyperram_bus_decoder_unit
// decodes hyperram bus events into select, command-address, wait, data and
// deselect symbols
// ----------------------------------------------------------------------------
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_stall   | in_item  (op, cs#, rwds, dq)
//   out     | output    | out_valid / out_stall | out_item (symbol and decode)
//   cfg     | input     | apb psel/penable      | initial latency, address 0-3
//
// one event per cycle while in_stall is low; out_item is a registered result
// the state machine updates in the cycle an event is taken
// in_stall rises only when both result register and skid entry are full
// synchronous active-low reset; latency register resets to 3
// ----------------------------------------------------------------------------
module hyperram_bus_decoder_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  hbd_pkg::in_item_t                in_item,
  output logic                             out_valid,
  input  logic                             out_stall,
  output hbd_pkg::out_item_t               out_item,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [hbd_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [hbd_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [hbd_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);

  logic [hbd_pkg::LAT_W-1:0] latency;
  logic                      accept;
  logic                      full;
  hbd_pkg::result_t          result;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  hbd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .latency     (latency)
  );

  hbd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .item    (in_item),
    .latency (latency),
    .result  (result)
  );

  hbd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .result    (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
